// ===== rtl/mh2_pkg.sv =====
// ----------------------------------------------------------------------------
// mh2_pkg
// Shared constants and types of the streaming MurmurHash2 engine.
// ----------------------------------------------------------------------------
package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  localparam int          CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_SEED      = 2'd0,
    REG_MESSAGE_LENGTH = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_FULL = 2'd0,
    OP_TAIL = 2'd1,
    OP_NONE = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        start;
    logic        last;
    logic [31:0] init;
    logic [31:0] word;
  } entry_t;

endpackage

// ===== rtl/murmur2_stream_hash.sv =====
// ----------------------------------------------------------------------------
// murmur2_stream_hash
// Streaming 32-bit MurmurHash2 of a message fed as little-endian words.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_stall  | data_word, byte_count, last_word
//   out     | output    | out_valid/out_stall| hash_value
//   cfg     | input     | cfg_wr_en          | cfg_index, cfg_wr_data
//
// A full word steps through K1, K2 and H in the hash sequencer, which owns one
// constant multiplier; a tail word steps through TAIL, and a last word adds the
// finalization states FIN1 and FIN2 (an empty last word goes straight to them).
// The queue holds QUEUE_DEPTH words so input is taken while the sequencer runs.
// Synchronous active-low reset clears control state; no clearing pass.
// in_stall rises only when the queue is full; a held result stalls finalization.
// ----------------------------------------------------------------------------
module murmur2_stream_hash #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mh2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_data_word,
  input  logic [2:0]                    in_byte_count,
  input  logic                          in_last_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_hash_value
);

  localparam int EW = $bits(mh2_pkg::entry_t);

  mh2_pkg::entry_t push_entry, pop_entry;
  logic            q_push, q_pop, q_full, q_empty;
  logic [EW-1:0]   pop_bits;

  mh2_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  mh2_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (EW'(push_entry)),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_bits),
    .empty     (q_empty)
  );

  assign pop_entry = mh2_pkg::entry_t'(pop_bits);

  mh2_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

// ===== rtl/mh2_fifo.sv =====
// ----------------------------------------------------------------------------
// mh2_fifo
// Small register queue between the word classifier and the hash engine.
// ----------------------------------------------------------------------------
module mh2_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mh2_front.sv =====
// ----------------------------------------------------------------------------
// mh2_front
// Accepts input words, tracks message boundaries, holds the configuration
// registers and classifies each word into a queue entry.
// ----------------------------------------------------------------------------
module mh2_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mh2_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [31:0]                      in_data_word,
  input  logic [2:0]                       in_byte_count,
  input  logic                             in_last_word,
  input  logic                             q_full,
  output logic                             q_push,
  output mh2_pkg::entry_t                  q_entry
);

  logic [31:0] seed_r;
  logic [15:0] len_r;
  logic        in_msg_r;
  logic [31:0] tail_mask;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    case (in_byte_count)
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      3'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  always_comb begin
    q_entry.start = !in_msg_r;
    q_entry.last  = in_last_word;
    q_entry.init  = seed_r ^ {16'h0000, len_r};
    if (!in_last_word || (in_byte_count inside {[3'd4:3'd7]})) begin
      q_entry.op   = mh2_pkg::OP_FULL;
      q_entry.word = in_data_word;
    end else if (in_byte_count != 3'd0) begin
      q_entry.op   = mh2_pkg::OP_TAIL;
      q_entry.word = in_data_word & tail_mask;
    end else begin
      q_entry.op   = mh2_pkg::OP_NONE;
      q_entry.word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      len_r    <= '0;
      in_msg_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          mh2_pkg::REG_HASH_SEED:      seed_r <= cfg_wr_data;
          mh2_pkg::REG_MESSAGE_LENGTH: len_r  <= cfg_wr_data[15:0];
          default: ;
        endcase
      end
      if (q_push) begin
        in_msg_r <= !in_last_word;
      end
    end
  end

endmodule

// ===== rtl/mh2_engine.sv =====
// ----------------------------------------------------------------------------
// mh2_engine
// Hash sequencer: one shared constant multiplier steps through word mixing,
// tail folding and finalization, and drives the result register.
// ----------------------------------------------------------------------------
module mh2_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  mh2_pkg::entry_t q_entry,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_hash_value
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_H,
    S_TAIL,
    S_FIN1,
    S_FIN2
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_comb begin
    case (state_r)
      S_K1:    mul_a = k_r;
      S_K2:    mul_a = k_r ^ (k_r >> mh2_pkg::MIX_SHIFT);
      S_H:     mul_a = h_r;
      S_TAIL:  mul_a = h_r ^ k_r;
      S_FIN1:  mul_a = h_r ^ (h_r >> mh2_pkg::FIN_SHIFT_A);
      default: mul_a = h_r;
    endcase
  end

  // low 32 bits of the product only
  assign prod = mul_a * mh2_pkg::MIX_MUL;

  assign q_pop          = (state_r == S_IDLE) && !q_empty;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          h_nxt    = q_entry.start ? q_entry.init : h_r;
          k_nxt    = q_entry.word;
          last_nxt = q_entry.last;
          case (q_entry.op)
            mh2_pkg::OP_FULL: state_nxt = S_K1;
            mh2_pkg::OP_TAIL: state_nxt = S_TAIL;
            default:          state_nxt = S_FIN1;
          endcase
        end
      end
      S_K1: begin
        k_nxt     = prod;
        state_nxt = S_K2;
      end
      S_K2: begin
        k_nxt     = prod;
        state_nxt = S_H;
      end
      S_H: begin
        h_nxt     = prod ^ k_r;
        state_nxt = last_r ? S_FIN1 : S_IDLE;
      end
      S_TAIL: begin
        h_nxt     = prod;
        state_nxt = last_r ? S_FIN1 : S_IDLE;
      end
      S_FIN1: begin
        h_nxt     = prod;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        if (!out_valid_r || !out_stall) begin
          out_hash_nxt  = h_r ^ (h_r >> mh2_pkg::FIN_SHIFT_B);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      h_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
    end
    k_r        <= k_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

// ===== tb/murmur2_stream_hash_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// murmur2_stream_hash_tb
// Self-checking bench for the streaming MurmurHash2 engine. Messages are
// streamed with random gaps and output stalls. A local hash model predicts
// each finalized hash, and the monitor compares every result transaction
// in order. Register settings change between phases, sometimes while a
// message is still open.
// ----------------------------------------------------------------------------
module murmur2_stream_hash_tb;

  localparam int CLK_PERIOD    = 10;
  localparam int MAX_IDLE      = 14;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int WORD_BYTES    = 4;

  // indexes past the last register, writes there must be ignored
  localparam logic [mh2_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [mh2_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [mh2_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_wr_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [31:0]                   in_data_word;
  logic [2:0]                    in_byte_count;
  logic                          in_last_word;
  logic                          out_valid;
  logic                          out_stall;
  logic [31:0]                   out_hash_value;

  // hash model state
  logic [31:0] seed_reg;
  logic [15:0] len_reg;
  logic [31:0] hash_acc;
  logic        msg_open;
  logic [31:0] hash_q[$];

  int  err_cnt;
  int  cycle_cnt;
  int  items_sent;
  bit  idle_en;
  bit  hold_req;

  murmur2_stream_hash uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int draw_gap();
    return idle_en ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] ERROR %s: got %08h expected %08h", $time, what, got, want);
    err_cnt++;
  endtask

  // advance the hash model by one accepted input transaction
  task automatic hash_accept(logic [31:0] word, logic [2:0] cnt, logic last);
    logic [2:0]      nbytes;
    logic [31:0]     h;
    logic [31:0]     k;
    logic [31:0]     mask;
    mh2_pkg::op_t    op;
    nbytes = (cnt > WORD_BYTES) ? 3'(WORD_BYTES) : cnt;
    h = msg_open ? hash_acc : (seed_reg ^ {16'h0, len_reg});
    if (!last || nbytes == WORD_BYTES) op = mh2_pkg::OP_FULL;
    else if (nbytes != 0) op = mh2_pkg::OP_TAIL;
    else op = mh2_pkg::OP_NONE;
    case (op)
      mh2_pkg::OP_FULL: begin
        k = word * mh2_pkg::MIX_MUL;
        k = k ^ (k >> mh2_pkg::MIX_SHIFT);
        k = k * mh2_pkg::MIX_MUL;
        h = (h * mh2_pkg::MIX_MUL) ^ k;
      end
      mh2_pkg::OP_TAIL: begin
        mask = (32'h1 << (8 * nbytes)) - 32'h1;
        h = (h ^ (word & mask)) * mh2_pkg::MIX_MUL;
      end
      default: ;
    endcase
    if (last) begin
      h = h ^ (h >> mh2_pkg::FIN_SHIFT_A);
      h = h * mh2_pkg::MIX_MUL;
      h = h ^ (h >> mh2_pkg::FIN_SHIFT_B);
      hash_q = {hash_q, h};
    end
    hash_acc = h;
    msg_open = !last;
  endtask

  task automatic write_reg(logic [mh2_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    if (idx == mh2_pkg::REG_HASH_SEED) seed_reg = data;
    else if (idx == mh2_pkg::REG_MESSAGE_LENGTH) len_reg = data[15:0];
  endtask

  task automatic send_item(logic [31:0] word, logic [2:0] cnt, logic last);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= word;
    in_byte_count <= cnt;
    in_last_word  <= last;
    do @(posedge clk); while (in_stall);
    hash_accept(word, cnt, last);
    items_sent++;
  endtask

  // drop valid, wait for every hash, then let the sequencer finish open words
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_body(int nwords);
    logic [2:0] cnt;
    for (int i = 0; i < nwords; i++) begin
      cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'(WORD_BYTES);
      send_item($urandom(), cnt, 1'b0);
    end
  endtask

  task automatic send_random_message();
    int nwords;
    nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    send_body(nwords);
    send_item($urandom(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (hash_q.size() == 0) begin
        report_mismatch("unexpected hash_value", out_hash_value, 32'h0);
      end else begin
        want = hash_q.pop_front();
        if (out_hash_value !== want) report_mismatch("hash_value", out_hash_value, want);
      end
    end
  end

  // result receiver: random stall per transaction, one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = draw_gap();
      end
      @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic test_reset_values();
    send_item(32'h0, 3'd0, 1'b1);
    send_item(32'h6c6c_6568, 3'd4, 1'b1);
    quiesce();
  endtask

  task automatic test_register_extremes();
    write_reg(mh2_pkg::REG_HASH_SEED, 32'hffff_ffff);
    write_reg(mh2_pkg::REG_MESSAGE_LENGTH, 32'hffff_ffff);
    send_item(32'hffff_ffff, 3'd4, 1'b0);
    send_item(32'hffff_ffff, 3'd3, 1'b1);
    quiesce();
    write_reg(REG_SPARE_2, 32'h1234_5678);
    write_reg(REG_SPARE_3, 32'hdead_beef);
    send_item(32'h0, 3'd0, 1'b1);
    quiesce();
    write_reg(mh2_pkg::REG_HASH_SEED, 32'h0);
    write_reg(mh2_pkg::REG_MESSAGE_LENGTH, 32'h0);
    send_item(32'h0, 3'd4, 1'b1);
    quiesce();
  endtask

  task automatic test_special_words();
    write_reg(mh2_pkg::REG_HASH_SEED, 32'h9747_b28c);
    write_reg(mh2_pkg::REG_MESSAGE_LENGTH, 32'd11);
    // short and oversized counts on non-last words still mix a full word
    send_item(32'haaaa_aaaa, 3'd1, 1'b0);
    send_item(32'h5555_5555, 3'd7, 1'b0);
    send_item(32'hffff_ffff, 3'd0, 1'b1);
    // tails of each size, unused bytes set
    for (int c = 1; c <= 3; c++) send_item(32'hffff_ffff, 3'(c), 1'b1);
    for (int c = 5; c <= 7; c++) send_item(32'h8000_0001, 3'(c), 1'b1);
    send_item(32'h0, 3'd4, 1'b0);
    send_item(32'h1234_5678, 3'd2, 1'b1);
    quiesce();
  endtask

  task automatic test_reconfig_mid_message();
    send_item(32'h0102_0304, 3'd4, 1'b0);
    send_item(32'h0506_0708, 3'd4, 1'b0);
    quiesce();
    write_reg(mh2_pkg::REG_HASH_SEED, 32'h0f0f_0f0f);
    write_reg(mh2_pkg::REG_MESSAGE_LENGTH, 32'h0000_ffff);
    send_item(32'h090a_0b0c, 3'd2, 1'b1);
    send_item(32'hcafe_f00d, 3'd4, 1'b1);
    quiesce();
  endtask

  task automatic test_output_hold();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_random_message();
    quiesce();
    idle_en = 1'b1;
  endtask

  task automatic test_random_stream();
    int target;
    int sel;
    target = RANDOM_ITEMS;
    while (items_sent < target) begin
      idle_en = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 3);
      if (sel == 0) write_reg(mh2_pkg::REG_HASH_SEED, 32'h0);
      else if (sel == 1) write_reg(mh2_pkg::REG_HASH_SEED, 32'hffff_ffff);
      else write_reg(mh2_pkg::REG_HASH_SEED, $urandom());
      sel = $urandom_range(0, 3);
      if (sel == 0) write_reg(mh2_pkg::REG_MESSAGE_LENGTH, 32'h0);
      else if (sel == 1) write_reg(mh2_pkg::REG_MESSAGE_LENGTH, 32'hffff);
      else write_reg(mh2_pkg::REG_MESSAGE_LENGTH, $urandom());
      if ($urandom_range(0, 4) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3, $urandom());
      for (int m = $urandom_range(10, 40); m > 0; m--) send_random_message();
      // sometimes leave a message open across the next register change
      if ($urandom_range(0, 2) == 0) send_body($urandom_range(1, 4));
      quiesce();
    end
    if (msg_open) begin
      send_item($urandom(), 3'($urandom_range(0, 7)), 1'b1);
      quiesce();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = mh2_pkg::REG_HASH_SEED;
    cfg_wr_data   = 32'h0;
    in_valid      = 1'b0;
    in_data_word  = 32'h0;
    in_byte_count = 3'd0;
    in_last_word  = 1'b0;
    seed_reg      = 32'h0;
    len_reg       = 16'h0;
    hash_acc      = 32'h0;
    msg_open      = 1'b0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    items_sent    = 0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_register_extremes();
    test_special_words();
    test_reconfig_mid_message();
    test_output_hold();
    test_random_stream();

    quiesce();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
